// ===== src/mtok_pkg.sv =====
// Shared types and constants for the mini C tokenizer.
// Used by every module under src; depends on nothing else.
package mtok_pkg;

    // Default size of the token buffer in characters.
    localparam int MTOK_MAX_TOKEN_CHARS = 32;

    // Width of length and index fields that cross the command queue.
    // It covers the largest supported buffer of 63 characters.
    localparam int TOKEN_LEN_W = 6;

    // Depth of the command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;

    // Token kinds as they appear on the result channel.
    typedef enum logic [3:0] {
        KIND_IDENT   = 4'd0,
        KIND_INT     = 4'd1,
        KIND_RETURN  = 4'd2,
        KIND_NUMBER  = 4'd3,
        KIND_ASSIGN  = 4'd4,
        KIND_PLUS    = 4'd5,
        KIND_SEMI    = 4'd6,
        KIND_LPAREN  = 4'd7,
        KIND_RPAREN  = 4'd8,
        KIND_LBRACE  = 4'd9,
        KIND_RBRACE  = 4'd10,
        KIND_EOF     = 4'd11,
        KIND_UNKNOWN = 4'd12
    } kind_t;

    // Scanner mode kept by the front end.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } mode_t;

    // Sequencer states of the back end.
    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_EMIT = 2'd2,
        BK_TAIL = 2'd3
    } back_state_t;

    // Input word: one source byte or an end marker.
    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
    } in_word_t;

    // Result word: one character of a token.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_char;
        logic       token_end;
        logic       truncated;
        logic       run_end;
    } out_word_t;

    // Command from the front end to the back end. A command may flush the
    // buffered token, emit a one-character tail and store one character into
    // the buffer; the store is made with the last flushed character, before any tail.
    typedef struct packed {
        logic                   has_flush;
        kind_t                  flush_kind;
        logic [TOKEN_LEN_W-1:0] flush_len;
        logic                   flush_trunc;
        logic                   has_tail;
        kind_t                  tail_kind;
        logic [7:0]             tail_char;
        logic                   do_append;
        logic [TOKEN_LEN_W-1:0] app_idx;
        logic [7:0]             app_char;
    } cmd_t;

endpackage

// ===== src/mini_c_tokenizer.sv =====
// Mini C tokenizer top level. A source word is taken whenever the
// four-entry command queue has room. The back end takes each queued command,
// reads each buffered token character from the buffer and then loads it into the
// output register, and loads a punctuator or eof result straight into the output register.
// Reset clears the scanner mode, counters, queue and output valid at once;
// the token buffer is not cleared and is only read where it was written.
module mini_c_tokenizer
    import mtok_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = MTOK_MAX_TOKEN_CHARS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_ready,
    input  in_word_t  char_word,
    output logic      tok_valid,
    input  logic      tok_ready,
    output out_word_t tok_word
);

    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    cmd_t q_head;
    logic q_full;
    logic q_empty;

    // Byte classification and token bookkeeping.
    mtok_front #(
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_word  (char_word),
        .char_ready (char_ready),
        .q_full     (q_full),
        .push       (q_push),
        .push_cmd   (q_push_cmd)
    );

    // Commands waiting for the back end.
    mtok_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Token buffer and result emission.
    mtok_back #(
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (q_head),
        .pop       (q_pop),
        .tok_valid (tok_valid),
        .tok_word  (tok_word),
        .tok_ready (tok_ready)
    );

`ifndef SYNTH
    // The front end never pushes into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // An end-of-file word closes its token and its run and carries a NUL.
    a_eof_word: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_word.kind == KIND_EOF) |->
        (tok_word.token_end && tok_word.run_end && tok_word.out_char == 8'h00
         && !tok_word.truncated))
        else $error("malformed end-of-file word");

    // Only buffered identifiers and numbers can be truncated.
    a_trunc_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_word.truncated) |->
        (tok_word.kind == KIND_IDENT || tok_word.kind == KIND_NUMBER))
        else $error("truncated flag on a kind that is never buffered");
`endif

endmodule

// ===== src/mtok_queue.sv =====
// Small command queue between the tokenizer front and back ends.
// Depends on mtok_pkg for the command type and depth.
module mtok_queue
    import mtok_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/mtok_front.sv =====
// Front end of the tokenizer: accepts source words, classifies each byte,
// tracks the scanner mode and token length, and issues back-end commands.
// Depends on mtok_pkg.
module mtok_front
    import mtok_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = MTOK_MAX_TOKEN_CHARS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     char_valid,
    input  in_word_t char_word,
    output logic     char_ready,
    input  logic     q_full,
    output logic     push,
    output cmd_t     push_cmd
);

    localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_ASSIGN = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LOW_I  = 8'h69;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_ASSIGN: k = KIND_ASSIGN;
            CH_PLUS:   k = KIND_PLUS;
            CH_SEMI:   k = KIND_SEMI;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            default:   k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Expected characters of the keywords by position.
    function automatic logic [7:0] kw_int_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h69;
            3'd1:    c = 8'h6E;
            3'd2:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kw_return_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h72;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h75;
            3'd4:    c = 8'h72;
            3'd5:    c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    mode_t            mode_reg;
    mode_t            mode_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             int_match_reg;
    logic             int_match_next;
    logic             ret_match_reg;
    logic             ret_match_next;

    logic             accept;
    logic [7:0]       c;
    logic             at_eof;
    logic             pending;
    logic             extend;
    kind_t            ident_kind;

    assign char_ready = !q_full;
    assign accept     = char_valid && !q_full;
    assign c          = char_word.char_code;
    assign at_eof     = char_word.op || (c == CH_NUL);
    assign pending    = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER);
    assign extend     = !at_eof
                      && (((mode_reg == MODE_IDENT) && (is_letter(c) || is_digit(c)))
                      || ((mode_reg == MODE_NUMBER) && is_digit(c)));

    // Keyword check on the buffered identifier, tracked as it was collected.
    always_comb
    begin
        ident_kind = KIND_IDENT;
        if (!ovf_reg && int_match_reg && len_reg == LEN_W'(3))
        begin
            ident_kind = KIND_INT;
        end
        else if (!ovf_reg && ret_match_reg && len_reg == LEN_W'(6))
        begin
            ident_kind = KIND_RETURN;
        end
    end

    // Classify the accepted byte and build the command for the back end.
    always_comb
    begin
        mode_next      = mode_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        int_match_next = int_match_reg;
        ret_match_next = ret_match_reg;
        push_cmd       = '0;
        if (accept)
        begin
            if (extend)
            begin
                if (len_reg < LEN_W'(MAX_TOKEN_CHARS))
                begin
                    push_cmd.do_append = 1'b1;
                    push_cmd.app_idx   = TOKEN_LEN_W'(len_reg);
                    push_cmd.app_char  = c;
                    len_next           = len_reg + LEN_W'(1);
                    int_match_next     = int_match_reg && (len_reg < LEN_W'(3))
                                       && (c == kw_int_char(len_reg[2:0]));
                    ret_match_next     = ret_match_reg && (len_reg < LEN_W'(6))
                                       && (c == kw_return_char(len_reg[2:0]));
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                if (pending)
                begin
                    push_cmd.has_flush   = 1'b1;
                    push_cmd.flush_kind  = (mode_reg == MODE_NUMBER) ? KIND_NUMBER
                                         : ident_kind;
                    push_cmd.flush_len   = TOKEN_LEN_W'(len_reg);
                    push_cmd.flush_trunc = ovf_reg;
                end
                mode_next = MODE_IDLE;
                len_next  = '0;
                ovf_next  = 1'b0;
                if (at_eof)
                begin
                    push_cmd.has_tail  = 1'b1;
                    push_cmd.tail_kind = KIND_EOF;
                    push_cmd.tail_char = CH_NUL;
                end
                else if (is_space(c))
                begin
                    // Whitespace only ends the pending token.
                end
                else if (is_letter(c) || is_digit(c))
                begin
                    mode_next          = is_letter(c) ? MODE_IDENT : MODE_NUMBER;
                    push_cmd.do_append = 1'b1;
                    push_cmd.app_idx   = '0;
                    push_cmd.app_char  = c;
                    len_next           = LEN_W'(1);
                    int_match_next     = (c == CH_LOW_I);
                    ret_match_next     = (c == CH_LOW_R);
                end
                else
                begin
                    push_cmd.has_tail  = 1'b1;
                    push_cmd.tail_kind = punct_kind(c);
                    push_cmd.tail_char = c;
                end
            end
        end
    end

    assign push = push_cmd.has_flush || push_cmd.has_tail || push_cmd.do_append;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            int_match_reg <= 1'b0;
            ret_match_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            int_match_reg <= int_match_next;
            ret_match_reg <= ret_match_next;
        end
    end

endmodule

// ===== src/mtok_back.sv =====
// Back end of the tokenizer: holds the token buffer, executes queued
// commands and drives the result channel through an output register.
// Depends on mtok_pkg.
module mtok_back
    import mtok_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = MTOK_MAX_TOKEN_CHARS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  cmd_t      head,
    output logic      pop,
    output logic      tok_valid,
    output out_word_t tok_word,
    input  logic      tok_ready
);

    localparam int IDX_W = $clog2(MAX_TOKEN_CHARS);

    logic [7:0]       token_mem [MAX_TOKEN_CHARS];
    logic [7:0]       rd_data_reg;

    back_state_t      state_reg;
    back_state_t      state_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    logic             out_valid_reg;
    out_word_t        out_word_reg;
    logic             out_free;
    logic             load;
    out_word_t        load_word;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             last;

    assign out_free  = !out_valid_reg || tok_ready;
    assign tok_valid = out_valid_reg;
    assign tok_word  = out_word_reg;
    assign last      = (TOKEN_LEN_W'(idx_reg) == cmd_reg.flush_len - TOKEN_LEN_W'(1));

    // Command sequencer: flush characters, then the tail; a buffer write that
    // comes with a flush is made together with the last flushed character.
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        load       = 1'b0;
        load_word  = '0;
        wr_en      = 1'b0;
        wr_addr    = head.app_idx[IDX_W-1:0];
        wr_data    = head.app_char;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    if (head.has_flush)
                    begin
                        idx_next   = '0;
                        state_next = BK_READ;
                    end
                    else if (head.has_tail)
                    begin
                        state_next = BK_TAIL;
                    end
                    else
                    begin
                        wr_en = head.do_append;
                    end
                end
            end
            BK_READ:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    load                = 1'b1;
                    load_word.kind      = cmd_reg.flush_kind;
                    load_word.out_char  = rd_data_reg;
                    load_word.token_end = last;
                    load_word.truncated = cmd_reg.flush_trunc;
                    load_word.run_end   = last && !cmd_reg.has_tail;
                    if (last)
                    begin
                        state_next = cmd_reg.has_tail ? BK_TAIL : BK_IDLE;
                        wr_en      = cmd_reg.do_append;
                        wr_addr    = cmd_reg.app_idx[IDX_W-1:0];
                        wr_data    = cmd_reg.app_char;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = BK_READ;
                    end
                end
            end
            BK_TAIL:
            begin
                if (out_free)
                begin
                    load                = 1'b1;
                    load_word.kind      = cmd_reg.tail_kind;
                    load_word.out_char  = cmd_reg.tail_char;
                    load_word.token_end = 1'b1;
                    load_word.truncated = 1'b0;
                    load_word.run_end   = 1'b1;
                    state_next          = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tok_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        if (load)
        begin
            out_word_reg <= load_word;
        end
    end

    // Token buffer: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            token_mem[wr_addr] <= wr_data;
        end
        if (state_reg == BK_READ)
        begin
            rd_data_reg <= token_mem[idx_reg];
        end
    end

endmodule

// ===== sim/tb_mini_c_tokenizer.sv =====
// Self-checking testbench for the mini C tokenizer: byte stimulus, result checks.
// Depends on src/mtok_pkg.sv for the word types and on src/mini_c_tokenizer.sv.
module tb_mini_c_tokenizer import mtok_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOKEN_CHARS = MTOK_MAX_TOKEN_CHARS;
    localparam int RANDOM_WORDS = 400;
    localparam int QUIET_FROM = 320;
    localparam int DRAIN_CYCLES = 40;

    // Predicts the token words for each accepted source word and checks the
    // words that leave the block against them in order.
    class token_scoreboard;
        out_word_t  expected_q[$];
        mode_t      mode;
        logic [7:0] text_buf[TOKEN_CHARS];
        int         text_len;
        bit         overflow;
        int         failures;

        function new();
            mode = MODE_IDLE;
            text_len = 0;
            overflow = 1'b0;
            failures = 0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void push_result(kind_t k, logic [7:0] ch, logic fin, logic cut);
            out_word_t w;
            w.kind = k;
            w.out_char = ch;
            w.token_end = fin;
            w.truncated = cut;
            w.run_end = 1'b0;
            expected_q.push_back(w);
        endfunction

        function void add_char(logic [7:0] c);
            if (text_len < TOKEN_CHARS)
            begin
                text_buf[text_len] = c;
                text_len++;
            end
            else
                overflow = 1'b1;
        endfunction

        // Emit the buffered token, if any, and go back to idle.
        function void flush_token();
            kind_t k;
            k = KIND_NUMBER;
            if (mode == MODE_IDENT)
            begin
                k = KIND_IDENT;
                if (!overflow && text_len == 3 &&
                    {text_buf[0], text_buf[1], text_buf[2]} == "int")
                    k = KIND_INT;
                else if (!overflow && text_len == 6 &&
                         {text_buf[0], text_buf[1], text_buf[2], text_buf[3],
                          text_buf[4], text_buf[5]} == "return")
                    k = KIND_RETURN;
            end
            if (mode == MODE_IDENT || mode == MODE_NUMBER)
                for (int i = 0; i < text_len; i++)
                    push_result(k, text_buf[i], i == text_len - 1, overflow);
            mode = MODE_IDLE;
            text_len = 0;
            overflow = 1'b0;
        endfunction

        // Work out the words that one accepted source word causes.
        function void note_word(in_word_t w);
            int        first;
            logic [7:0] c;
            kind_t     k;
            out_word_t last;
            first = expected_q.size();
            c = w.char_code;
            if (w.op || c == 8'd0)
            begin
                flush_token();
                push_result(KIND_EOF, 8'd0, 1'b1, 1'b0);
            end
            else if (mode == MODE_IDENT && (is_letter(c) || is_digit(c)))
                add_char(c);
            else if (mode == MODE_NUMBER && is_digit(c))
                add_char(c);
            else
            begin
                flush_token();
                if (c == " " || (c >= 8'd9 && c <= 8'd13))
                begin
                    // Whitespace only ends the pending token.
                end
                else if (is_letter(c))
                begin
                    mode = MODE_IDENT;
                    add_char(c);
                end
                else if (is_digit(c))
                begin
                    mode = MODE_NUMBER;
                    add_char(c);
                end
                else
                begin
                    case (c)
                        "=":     k = KIND_ASSIGN;
                        "+":     k = KIND_PLUS;
                        ";":     k = KIND_SEMI;
                        "(":     k = KIND_LPAREN;
                        ")":     k = KIND_RPAREN;
                        "{":     k = KIND_LBRACE;
                        "}":     k = KIND_RBRACE;
                        default: k = KIND_UNKNOWN;
                    endcase
                    push_result(k, c, 1'b1, 1'b0);
                end
            end
            // The last word of the run carries the run end flag.
            if (expected_q.size() > first)
            begin
                last = expected_q.pop_back();
                last.run_end = 1'b1;
                expected_q.push_back(last);
            end
        endfunction

        function void flag_mismatch(string field, logic [7:0] want, logic [7:0] seen);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
            failures++;
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: word with nothing expected, expected none, actual %0h",
                         $time, got);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                flag_mismatch("kind", 8'(want.kind), 8'(got.kind));
            if (got.out_char !== want.out_char)
                flag_mismatch("out_char", want.out_char, got.out_char);
            if (got.token_end !== want.token_end)
                flag_mismatch("token_end", 8'(want.token_end), 8'(got.token_end));
            if (got.truncated !== want.truncated)
                flag_mismatch("truncated", 8'(want.truncated), 8'(got.truncated));
            if (got.run_end !== want.run_end)
                flag_mismatch("run_end", 8'(want.run_end), 8'(got.run_end));
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      char_valid = 1'b0;
    logic      char_ready;
    in_word_t  char_word = '0;
    logic      tok_valid;
    logic      tok_ready = 1'b0;
    out_word_t tok_word;

    token_scoreboard tokens = new();
    bit              quiet_tail = 1'b0;
    int              stall_left = 0;

    mini_c_tokenizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_word  (char_word),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_word   (tok_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hand one source word to the block, with an occasional gap before it.
    task automatic send_word(input logic op, input logic [7:0] c);
        in_word_t w;
        w.op = op;
        w.char_code = c;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_word <= w;
        do
            @(posedge clk);
        while (!char_ready);
        tokens.note_word(w);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(1'b0, s[i]);
    endtask

    function automatic logic [7:0] name_char(bit allow_digit);
        int n;
        n = allow_digit ? $urandom_range(0, 62) : $urandom_range(0, 52);
        if (n < 26)
            return 8'("a" + n);
        else if (n < 52)
            return 8'("A" + n - 26);
        else if (allow_digit && n < 62)
            return 8'("0" + n - 52);
        return "_";
    endfunction

    // Mostly short tokens, now and then a long one that can overrun the buffer.
    function automatic int pick_len();
        return ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
    endfunction

    // Drain side: check each accepted word and stall in random bursts.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && tok_valid && tok_ready)
                tokens.check_word(tok_word);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    tok_ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12);
                tok_ready <= 1'b0;
            end
            else
                tok_ready <= 1'b1;
        end
    end

    // Stimulus: a directed sentence, then random token streams.
    initial
    begin
        int         counted;
        int         len;
        string      kw;
        logic [7:0] c;

        counted = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Keywords, punctuators, every whitespace byte, high bytes, NUL and end.
        send_text("int\treturn\n;x9 =(1)+{}\013\014\015");
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h80);
        send_text("7");
        send_word(1'b1, 8'hA5);
        send_text("_");
        send_word(1'b0, 8'h00);

        while (counted < RANDOM_WORDS)
        begin
            if (counted >= QUIET_FROM)
                quiet_tail = 1'b1;
            case ($urandom_range(0, 19)) inside
                [0:5]:
                begin
                    len = pick_len();
                    send_word(1'b0, name_char(1'b0));
                    for (int i = 1; i < len; i++)
                        send_word(1'b0, name_char(1'b1));
                    counted += len;
                end
                [6:7]:
                begin
                    if ($urandom_range(0, 1) == 0)
                        kw = "int";
                    else
                        kw = "return";
                    case ($urandom_range(0, 3))
                        0:       kw = kw.substr(0, kw.len() - 2);
                        1:       kw = {kw, string'(name_char(1'b1))};
                        default: ;
                    endcase
                    send_text(kw);
                    counted += kw.len();
                end
                [8:10]:
                begin
                    len = pick_len();
                    for (int i = 0; i < len; i++)
                        send_word(1'b0, 8'("0" + $urandom_range(0, 9)));
                    counted += len;
                end
                [11:13]:
                begin
                    kw = "=+;(){}";
                    send_word(1'b0, kw[$urandom_range(0, 6)]);
                    counted++;
                end
                [14:15]:
                begin
                    c = ($urandom_range(0, 5) == 0) ? " " : 8'($urandom_range(9, 13));
                    send_word(1'b0, c);
                end
                16:
                begin
                    send_word(1'b0, 8'($urandom_range(0, 255)));
                    counted++;
                end
                17:
                begin
                    send_word(1'b0, 8'($urandom_range(128, 255)));
                    counted++;
                end
                18:
                begin
                    send_word(1'b0, 8'h00);
                    counted++;
                end
                default:
                begin
                    send_word(1'b1, 8'($urandom_range(0, 255)));
                    counted++;
                end
            endcase
        end
        char_valid <= 1'b0;

        // Wait for every expected word, then watch for strays.
        while (tokens.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tokens.failures == 0)
            $display("mini_c_tokenizer verification clean");
        else
            $display("mini_c_tokenizer verification failed");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #20ms;
        $display("mini_c_tokenizer verification failed");
        $finish;
    end

endmodule
